>>> hw/rtl/hsc_pkg.sv
// shared types and constants for the request signature classifier
// beat structs, reason codes, method and pattern byte strings
package hsc_pkg;

    localparam int WIN_BYTES  = 6;
    localparam int METH_BYTES = 7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } hsc_in_t;

    typedef struct packed {
        logic       suspicious;
        logic [2:0] reason;
    } hsc_out_t;

    typedef logic [2:0] hsc_reason_t;
    localparam hsc_reason_t RSN_CLEAN     = 3'd0;
    localparam hsc_reason_t RSN_BAD_METH  = 3'd1;
    localparam hsc_reason_t RSN_SQL       = 3'd2;
    localparam hsc_reason_t RSN_SHORT     = 3'd3;
    localparam hsc_reason_t RSN_TOOL      = 3'd4;

    localparam logic [7:0] MIN_LEN_RST = 8'd10;

    // accepted methods, first byte highest, zero padded to 7 bytes
    localparam logic [55:0] METH_GET     = 56'h47_45_54;
    localparam logic [55:0] METH_POST    = 56'h50_4f_53_54;
    localparam logic [55:0] METH_HEAD    = 56'h48_45_41_44;
    localparam logic [55:0] METH_OPTIONS = 56'h4f_50_54_49_4f_4e_53;

    // sql fragments, newest byte lowest
    localparam logic [31:0] SQL_OR    = 32'h20_4f_52_20;
    localparam logic [15:0] SQL_DASH  = 16'h2d_2d;
    localparam logic [15:0] SQL_QUOTE = 16'h27_3b;

    // scanner and client names
    localparam logic [47:0] TOOL_A = 48'h73_71_6c_6d_61_70;
    localparam logic [39:0] TOOL_B = 40'h4e_69_6b_74_6f;
    localparam logic [31:0] TOOL_C = 32'h63_75_72_6c;
    localparam logic [31:0] TOOL_D = 32'h77_67_65_74;
    localparam logic [31:0] TOOL_E = 32'h6e_6d_61_70;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0d));
    endfunction

endpackage

>>> hw/rtl/hsc_byte_cell.sv
// one byte cell of a shift chain: loads its neighbor's byte on shift
// used for the recent-byte window and the method text; no package use
module hsc_byte_cell (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       clear,
    input  logic       shift,
    input  logic [7:0] d_in,
    output logic [7:0] q
);
    logic [7:0] q_reg;
    logic [7:0] q_next;

    always_comb begin
        q_next = q_reg;
        if (clear) begin
            q_next = 8'd0;
        end else if (shift) begin
            q_next = d_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= 8'd0;
        end else begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;
endmodule

>>> hw/rtl/http_request_signature_classifier_core.sv
// top level of the request signature classifier
// depends on hsc_pkg and hsc_byte_cell (window and method chains)
//
// usage: request bytes enter on the s_ channel, one beat per byte, with
// s_data.last on the final byte. a zero byte ends the text and the rest of
// the request up to last is ignored. one verdict beat (suspicious, reason)
// leaves on the m_ channel for each request in the cycle after its last byte
// is accepted. non-last bytes produce nothing.
// throughput: one byte per cycle while no verdict waits on m_ready; a new
// request may start in the cycle after the previous last byte. the per-byte
// work is one shift of two byte chains (six window cells, seven method cells)
// plus pattern compares. the verdict sits in a single output register; while
// it waits for m_ready, s_ready is low, and it rises in the same cycle the
// verdict is taken, so a steady stream is not slowed.
// min_length is written through cfg_valid/cfg_data (always ready) and
// should only change between requests.
// reset (aresetn low, synchronous) clears all request state, drops
// m_valid and sets min_length to 10.
module http_request_signature_classifier_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  hsc_pkg::hsc_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output hsc_pkg::hsc_out_t m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [7:0]       cfg_data
);
    import hsc_pkg::*;

    logic [7:0] win_q  [WIN_BYTES];
    logic [7:0] win_n  [WIN_BYTES];
    logic [7:0] meth_q [METH_BYTES];
    logic [7:0] meth_n [METH_BYTES];

    logic [7:0]  min_len_reg;
    logic [2:0]  meth_cnt_reg, meth_cnt_next;
    logic        meth_closed_reg, meth_closed_next;
    logic        sql_reg, sql_next;
    logic        tool_reg, tool_next;
    logic [7:0]  len_reg, len_next;
    logic        ended_reg, ended_next;
    logic        out_valid_reg, out_valid_next;
    hsc_out_t    out_data_reg, out_data_next;

    logic        in_acc;
    logic        req_done;
    logic        byte_take;
    logic        meth_take;
    logic [7:0]  b;
    logic [47:0] win_vec;
    logic [55:0] meth_vec;
    logic        sql_hit, tool_hit, meth_ok;
    hsc_reason_t rsn;

    assign b        = s_data.data_byte;
    assign s_ready  = !out_valid_reg || m_ready;
    assign in_acc   = s_valid && s_ready;
    assign req_done = in_acc && s_data.last;
    assign byte_take = in_acc && !ended_reg && (b != 8'd0);
    assign meth_take = byte_take && !meth_closed_reg && !is_space(b);
    assign cfg_ready = 1'b1;

    // window chain: cell 0 holds the newest byte
    for (genvar i = 0; i < WIN_BYTES; i++) begin : g_win
        if (i == 0) begin : g_head
            assign win_n[i] = b;
        end else begin : g_body
            assign win_n[i] = win_q[i-1];
        end
        hsc_byte_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .clear   (req_done),
            .shift   (byte_take),
            .d_in    (win_n[i]),
            .q       (win_q[i])
        );
        assign win_vec[8*i +: 8] = win_n[i];
    end

    // method chain: cell 0 holds the latest method byte
    for (genvar k = 0; k < METH_BYTES; k++) begin : g_meth
        logic [7:0] d;
        if (k == 0) begin : g_head
            assign d = b;
        end else begin : g_body
            assign d = meth_q[k-1];
        end
        assign meth_n[k] = meth_take ? d : meth_q[k];
        hsc_byte_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .clear   (req_done),
            .shift   (meth_take),
            .d_in    (d),
            .q       (meth_q[k])
        );
        assign meth_vec[8*k +: 8] = meth_n[k];
    end

    // window as it stands once this byte is in
    assign sql_hit = (win_vec[31:0] == SQL_OR) || (win_vec[15:0] == SQL_DASH)
                  || (win_vec[15:0] == SQL_QUOTE);
    assign tool_hit = (win_vec[47:0] == TOOL_A) || (win_vec[39:0] == TOOL_B)
                   || (win_vec[31:0] == TOOL_C) || (win_vec[31:0] == TOOL_D)
                   || (win_vec[31:0] == TOOL_E);

    always_comb begin
        meth_cnt_next    = meth_cnt_reg;
        meth_closed_next = meth_closed_reg;
        sql_next         = sql_reg;
        tool_next        = tool_reg;
        len_next         = len_reg;
        ended_next       = ended_reg;
        if (in_acc && !ended_reg && (b == 8'd0)) begin
            ended_next = 1'b1;
        end
        if (byte_take) begin
            if (len_reg != 8'hff) begin
                len_next = len_reg + 8'd1;
            end
            if (!meth_closed_reg) begin
                if (is_space(b)) begin
                    meth_closed_next = 1'b1;
                end else begin
                    meth_cnt_next = meth_cnt_reg + 3'd1;
                    if (meth_cnt_reg == 3'(METH_BYTES - 1)) begin
                        meth_closed_next = 1'b1;
                    end
                end
            end
            sql_next  = sql_reg || sql_hit;
            tool_next = tool_reg || tool_hit;
        end
    end

    assign meth_ok = ((meth_cnt_next == 3'd3) && (meth_vec == METH_GET))
                  || ((meth_cnt_next == 3'd4) && (meth_vec == METH_POST))
                  || ((meth_cnt_next == 3'd4) && (meth_vec == METH_HEAD))
                  || ((meth_cnt_next == 3'd7) && (meth_vec == METH_OPTIONS));

    always_comb begin
        if (!meth_ok) begin
            rsn = RSN_BAD_METH;
        end else if (sql_next) begin
            rsn = RSN_SQL;
        end else if (len_next < min_len_reg) begin
            rsn = RSN_SHORT;
        end else if (tool_next) begin
            rsn = RSN_TOOL;
        end else begin
            rsn = RSN_CLEAN;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (req_done) begin
            out_valid_next           = 1'b1;
            out_data_next.suspicious = (rsn != RSN_CLEAN);
            out_data_next.reason     = rsn;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg     <= MIN_LEN_RST;
            meth_cnt_reg    <= 3'd0;
            meth_closed_reg <= 1'b0;
            sql_reg         <= 1'b0;
            tool_reg        <= 1'b0;
            len_reg         <= 8'd0;
            ended_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                min_len_reg <= cfg_data;
            end
            if (req_done) begin
                meth_cnt_reg    <= 3'd0;
                meth_closed_reg <= 1'b0;
                sql_reg         <= 1'b0;
                tool_reg        <= 1'b0;
                len_reg         <= 8'd0;
                ended_reg       <= 1'b0;
            end else begin
                meth_cnt_reg    <= meth_cnt_next;
                meth_closed_reg <= meth_closed_next;
                sql_reg         <= sql_next;
                tool_reg        <= tool_next;
                len_reg         <= len_next;
                ended_reg       <= ended_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;
endmodule
